/* hdl/ptce_pkg.sv */
// ptce_pkg: shared types and codes for the prefix tree counter engine
// no dependencies; imported by ptce_alu and the engine core
`default_nettype none

package ptce_pkg;

	// operation of one letter request
	typedef enum logic [1:0] {
		OP_INSERT       = 2'd0,
		OP_ERASE        = 2'd1,
		OP_COUNT_WORD   = 2'd2,
		OP_COUNT_PREFIX = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	localparam int SYMBOL_W = 5;
	localparam int TALLY_W  = 32;

	// one input request: a single letter of a word
	typedef struct packed {
		op_t                 op;
		logic [SYMBOL_W-1:0] symbol;
		logic                last;
	} item_t;

	// one result request, given on the final letter
	typedef struct packed {
		status_t                    status;
		logic signed [TALLY_W-1:0]  tally;
	} result_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADDR,
		S_CHILD,
		S_PASS,
		S_LOOK,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

/* hdl/ptce_ram.sv */
// ptce_ram: simple dual port memory, one write and one registered read port
// depends on nothing; used for the child table and both counter stores
`default_nettype none

module ptce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/ptce_alu.sv */
// ptce_alu: shared counter adder, increments on insert and decrements otherwise
// depends on ptce_pkg for the op codes
`default_nettype none

module ptce_alu
	import ptce_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  wire op_t              op,
	input  wire logic [WIDTH-1:0] operand,
	output logic      [WIDTH-1:0] sum
);

	// wrapping step of one
	always_comb begin
		if (op == OP_INSERT) begin
			sum = operand + WIDTH'(1);
		end else begin
			sum = operand - WIDTH'(1);
		end
	end

endmodule

`default_nettype wire

/* hdl/prefix_tree_counter_engine_core.sv */
// prefix tree counter engine: letter trie over a fixed node pool
// walk: a letter passes S_IDLE then S_LOOK on a failed walk, with S_ADDR and S_CHILD between
// them on a lookup, and S_PASS after S_CHILD when an existing node's pass count is updated;
// the final letter adds S_FIN (end count update and result load), held while the result slot is still held
// throughput: one letter at a time, set by the child table read then the counter
// read-modify-write through one shared adder
// reset: child table cleared one entry a cycle over all NODES*ALPHABET entries, item_stall high
`default_nettype none

module prefix_tree_counter_engine_core
	import ptce_pkg::*;
#(
	parameter int NODES      = 4096,
	parameter int ALPHABET   = 26,
	parameter int COUNT_BITS = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int NODE_W      = $clog2(NODES);
	localparam int CHILD_DEPTH = NODES * ALPHABET;
	localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
	localparam int SYM_CMP_W   = 9;

	// sequencer and walk state
	state_t                state_q, state_d;
	logic [CHILD_AW-1:0]   clr_q, clr_d;
	logic [NODE_W-1:0]     walk_q, walk_d;
	status_t               failed_q, failed_d;
	logic [NODE_W-1:0]     alloc_q, alloc_d;
	logic                  res_valid_q, res_valid_d;

	// payload of the letter in progress
	op_t                   op_q;
	logic [SYMBOL_W-1:0]   sym_q;
	logic                  last_q;
	logic [CHILD_AW-1:0]   slot_q;
	logic [CHILD_AW-1:0]   slot_d;
	result_t               res_q, res_d;

	// memory ports
	logic                  child_we, child_re;
	logic [CHILD_AW-1:0]   child_waddr, child_raddr;
	logic [NODE_W-1:0]     child_wdata, child_rdata;
	logic                  pass_we, pass_re;
	logic [NODE_W-1:0]     pass_waddr, pass_raddr;
	logic [COUNT_BITS-1:0] pass_wdata, pass_rdata;
	logic                  end_we, end_re;
	logic [NODE_W-1:0]     end_waddr, end_raddr;
	logic [COUNT_BITS-1:0] end_wdata, end_rdata;

	// shared adder
	logic [COUNT_BITS-1:0] alu_in, alu_out;

	logic                  accept, res_load, slot_free;
	logic                  sym_bad, child_missing, pool_full;
	logic [NODE_W:0]       alloc_next;

	ptce_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
		.clk     (clk),
		.wr_en   (child_we),
		.wr_addr (child_waddr),
		.wr_data (child_wdata),
		.rd_en   (child_re),
		.rd_addr (child_raddr),
		.rd_data (child_rdata)
	);

	ptce_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODES)) u_pass (
		.clk     (clk),
		.wr_en   (pass_we),
		.wr_addr (pass_waddr),
		.wr_data (pass_wdata),
		.rd_en   (pass_re),
		.rd_addr (pass_raddr),
		.rd_data (pass_rdata)
	);

	ptce_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODES)) u_end (
		.clk     (clk),
		.wr_en   (end_we),
		.wr_addr (end_waddr),
		.wr_data (end_wdata),
		.rd_en   (end_re),
		.rd_addr (end_raddr),
		.rd_data (end_rdata)
	);

	ptce_alu #(.WIDTH(COUNT_BITS)) u_alu (
		.op      (op_q),
		.operand (alu_in),
		.sum     (alu_out)
	);

	// handshake and decode helpers
	assign item_stall    = (state_q != S_IDLE);
	assign accept        = item_valid && !item_stall;
	assign slot_free     = !res_valid_q || !result_stall;
	assign sym_bad       = (SYM_CMP_W'(item.symbol) >= SYM_CMP_W'(ALPHABET));
	assign child_missing = (child_rdata == '0) ||
		((NODE_W+1)'(child_rdata) >= (NODE_W+1)'(NODES));
	assign alloc_next    = (NODE_W+1)'(alloc_q) + (NODE_W+1)'(1);
	assign pool_full     = (alloc_next >= (NODE_W+1)'(NODES));

	// adder operand: zero for a fresh node, else the counter just read
	always_comb begin
		unique case (state_q)
			S_CHILD: alu_in = '0;
			S_PASS:  alu_in = pass_rdata;
			default: alu_in = end_rdata;
		endcase
	end

	// sequencer: next state, memory controls and result
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		walk_d      = walk_q;
		failed_d    = failed_q;
		alloc_d     = alloc_q;
		slot_d      = slot_q;
		res_d       = res_q;
		res_load    = 1'b0;
		child_we    = 1'b0;
		child_waddr = slot_q;
		child_wdata = alloc_next[NODE_W-1:0];
		child_re    = 1'b0;
		child_raddr = CHILD_AW'(walk_q) * CHILD_AW'(ALPHABET) + CHILD_AW'(sym_q);
		pass_we     = 1'b0;
		pass_waddr  = walk_q;
		pass_wdata  = alu_out;
		pass_re     = 1'b0;
		pass_raddr  = walk_q;
		end_we      = 1'b0;
		end_waddr   = walk_q;
		end_wdata   = alu_out;
		end_re      = 1'b0;
		end_raddr   = walk_q;
		unique case (state_q)
			S_CLEAR: begin
				child_we    = 1'b1;
				child_waddr = clr_q;
				child_wdata = '0;
				clr_d       = clr_q + CHILD_AW'(1);
				if (clr_q == CHILD_AW'(CHILD_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (failed_q != ST_OK) begin
						state_d = S_LOOK;
					end else if (sym_bad) begin
						failed_d = ST_MISSING;
						state_d  = S_LOOK;
					end else begin
						state_d = S_ADDR;
					end
				end
			end
			S_ADDR: begin
				child_re = 1'b1;
				slot_d   = child_raddr;
				state_d  = S_CHILD;
			end
			S_CHILD: begin
				state_d = S_LOOK;
				if (child_missing) begin
					if (op_q != OP_INSERT) begin
						failed_d = ST_MISSING;
					end else if (pool_full) begin
						failed_d = ST_FULL;
					end else begin
						// allocate a node with pass count one, end count zero
						child_we   = 1'b1;
						alloc_d    = alloc_next[NODE_W-1:0];
						walk_d     = alloc_next[NODE_W-1:0];
						pass_we    = 1'b1;
						pass_waddr = alloc_next[NODE_W-1:0];
						end_we     = 1'b1;
						end_waddr  = alloc_next[NODE_W-1:0];
						end_wdata  = '0;
					end
				end else begin
					walk_d = child_rdata;
					if (op_q == OP_INSERT || op_q == OP_ERASE) begin
						pass_re    = 1'b1;
						pass_raddr = child_rdata;
						state_d    = S_PASS;
					end
				end
			end
			S_PASS: begin
				pass_we = 1'b1;
				state_d = S_LOOK;
			end
			S_LOOK: begin
				if (!last_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_FIN;
					if (failed_q == ST_OK) begin
						if (op_q == OP_COUNT_PREFIX) begin
							pass_re = 1'b1;
						end else begin
							end_re = 1'b1;
						end
					end
				end
			end
			S_FIN: begin
				if (slot_free) begin
					res_load     = 1'b1;
					res_d.status = failed_q;
					res_d.tally  = '0;
					if (failed_q == ST_OK) begin
						unique case (op_q)
							OP_INSERT, OP_ERASE: end_we = 1'b1;
							OP_COUNT_WORD:   res_d.tally = TALLY_W'($signed(end_rdata));
							OP_COUNT_PREFIX: res_d.tally = TALLY_W'($signed(pass_rdata));
							default:         res_d.tally = '0;
						endcase
					end
					walk_d   = '0;
					failed_d = ST_OK;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result slot
	always_comb begin
		if (res_load) begin
			res_valid_d = 1'b1;
		end else if (!result_stall) begin
			res_valid_d = 1'b0;
		end else begin
			res_valid_d = res_valid_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			walk_q      <= '0;
			failed_q    <= ST_OK;
			alloc_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			walk_q      <= walk_d;
			failed_q    <= failed_d;
			alloc_q     <= alloc_d;
			res_valid_q <= res_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= item.op;
			sym_q  <= item.symbol;
			last_q <= item.last;
		end
		slot_q <= slot_d;
		res_q  <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// no request taken while the child table is being cleared
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> item_stall)
		else $error("request accepted during clearing pass");

	// the node pool only grows
	a_alloc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (alloc_q >= $past(alloc_q)))
		else $error("allocation pointer went backwards");

	// a failed word reports a zero tally
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != ST_OK) |-> (result.tally == '0))
		else $error("non-zero tally on failed word");

	// the walk restarts at the root after a result
	a_walk_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (walk_q == '0 && failed_q == ST_OK && res_valid_q))
		else $error("walk not restarted after result");

endmodule

`default_nettype wire

/* tb/sv/trie_count_checker.sv */
`timescale 1ns / 1ps
// trie_count_checker: watches both request channels of the prefix tree counter engine,
// keeps its own trie to predict each word result and compares; depends on ptce_pkg
module trie_count_checker
	import ptce_pkg::*;
#(
	parameter int NODES      = 4096,
	parameter int ALPHABET   = 26,
	parameter int COUNT_BITS = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	input  wire logic    item_stall,
	input  wire item_t   item,
	input  wire logic    result_valid,
	input  wire logic    result_stall,
	input  wire result_t result,
	output int           words_pending,
	output int           mismatches
);

	localparam int NODE_W = $clog2(NODES);

	// private copy of the trie and the walk in progress
	bit [NODE_W-1:0]     child_of [NODES*ALPHABET];
	bit [COUNT_BITS-1:0] pass_cnt [NODES];
	bit [COUNT_BITS-1:0] end_cnt  [NODES];
	int unsigned         newest_node;
	int unsigned         cur_node;
	status_t             walk_status;

	// word results still owed by the engine, oldest first
	result_t             due_results [$];
	int                  due_total  = 0;
	int                  miss_total = 0;

	assign words_pending = due_total;
	assign mismatches    = miss_total;

	// one step down the trie; insert grows missing children while the pool lasts
	function automatic void trie_descend(op_t op, logic [SYMBOL_W-1:0] sym);
		int unsigned slot;
		int unsigned nxt;
		if (sym >= ALPHABET) begin
			walk_status = ST_MISSING;
			return;
		end
		slot = cur_node * ALPHABET + sym;
		nxt  = child_of[slot];
		if (nxt == 0) begin
			if (op != OP_INSERT) begin
				walk_status = ST_MISSING;
				return;
			end
			if (newest_node + 1 >= NODES) begin
				walk_status = ST_FULL;
				return;
			end
			newest_node++;
			nxt = newest_node;
			child_of[slot] = NODE_W'(nxt);
		end
		cur_node = nxt;
		if (op == OP_INSERT)
			pass_cnt[nxt] = pass_cnt[nxt] + 1'b1;
		else if (op == OP_ERASE)
			pass_cnt[nxt] = pass_cnt[nxt] - 1'b1;
	endfunction

	// apply one letter; returns 1 with the word result on the final letter
	function automatic bit trie_take_letter(item_t req, output result_t res);
		int unsigned n;
		res.status = ST_OK;
		res.tally  = '0;
		if (walk_status == ST_OK)
			trie_descend(req.op, req.symbol);
		if (!req.last)
			return 1'b0;
		n = cur_node;
		if (walk_status == ST_OK) begin
			case (req.op)
				OP_INSERT:     end_cnt[n] = end_cnt[n] + 1'b1;
				OP_ERASE:      end_cnt[n] = end_cnt[n] - 1'b1;
				OP_COUNT_WORD: res.tally = TALLY_W'(signed'(end_cnt[n]));
				default:       res.tally = TALLY_W'(signed'(pass_cnt[n]));
			endcase
		end
		res.status  = walk_status;
		cur_node    = 0;
		walk_status = ST_OK;
		return 1'b1;
	endfunction

	// predict on each accepted letter, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			foreach (child_of[i])
				child_of[i] = '0;
			foreach (pass_cnt[i]) begin
				pass_cnt[i] = '0;
				end_cnt[i]  = '0;
			end
			newest_node = 0;
			cur_node    = 0;
			walk_status = ST_OK;
			due_results.delete();
			due_total = 0;
		end else begin
			if (item_valid && !item_stall) begin
				if (trie_take_letter(item, want))
					due_results.push_back(want);
			end
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$error("result with none expected: status %0d tally %0d",
						result.status, result.tally);
					miss_total++;
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						miss_total++;
					end
					if (result.tally !== want.tally) begin
						$error("tally: expected %0d, got %0d", want.tally, result.tally);
						miss_total++;
					end
				end
			end
			due_total = due_results.size();
		end
	end

endmodule

/* tb/sv/tb_prefix_tree_counter_engine_core.sv */
`timescale 1ns / 1ps
// tb_prefix_tree_counter_engine_core: sends letter requests into the prefix tree
// counter engine and gives the verdict; depends on ptce_pkg and trie_count_checker
module tb_prefix_tree_counter_engine_core;
	import ptce_pkg::*;

	localparam int MAX_LEN     = 32;
	localparam int IDLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam int ALPHA_FULL  = 26;

	typedef struct packed {
		logic [5:0]                       len;
		logic [MAX_LEN-1:0][SYMBOL_W-1:0] sym;
	} word_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	int      words_pending;
	int      mismatches;
	int      letters_sent = 0;
	int      words_sent   = 0;
	int      idle_cycles  = 0;
	bit      quiet        = 1'b0;
	word_t   known_words [$];

	prefix_tree_counter_engine_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	trie_count_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.words_pending (words_pending),
		.mismatches    (mismatches)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: cycles with no request moving on either side, covers the clearing pass
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver back-pressure, off during the quiet stretch
	always @(posedge clk)
		result_stall <= !quiet && ($urandom_range(99) < 18);

	// one letter request, with random idle cycles ahead of it
	task automatic send_letter(op_t op, logic [SYMBOL_W-1:0] sym, bit fin);
		item_t req;
		req.op     = op;
		req.symbol = sym;
		req.last   = fin;
		while (!quiet && $urandom_range(99) < 18) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		letters_sent++;
		if (fin)
			words_sent++;
	endtask

	task automatic send_word(op_t op, word_t w);
		for (int i = 0; i < w.len; i++)
			send_letter(op, w.sym[i], i == w.len - 1);
	endtask

	// random word over the first span letters
	function automatic word_t fresh_word(int min_len, int max_len, int span);
		word_t w;
		w     = '0;
		w.len = 6'($urandom_range(max_len, min_len));
		for (int i = 0; i < w.len; i++)
			w.sym[i] = SYMBOL_W'($urandom_range(span - 1));
		return w;
	endfunction

	// each letter under its own op, symbols over the whole field
	task automatic noise_word();
		int n;
		n = $urandom_range(5, 1);
		for (int i = 0; i < n; i++)
			send_letter(op_t'($urandom_range(3)), SYMBOL_W'($urandom_range(31)), i == n - 1);
	endtask

	// hold the sender until every word result has come back
	task automatic drain();
		item_valid <= 1'b0;
		@(negedge clk);
		while (words_pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// mostly well-formed words on known paths, some misses and noise
	task automatic random_words(int budget);
		int    stop;
		int    roll;
		word_t w;
		op_t   op;
		stop = letters_sent + budget;
		while (letters_sent < stop) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				if ($urandom_range(1) == 1) begin
					w = known_words[$urandom_range(known_words.size() - 1)];
				end else begin
					w = fresh_word(1, 6, ($urandom_range(3) == 0) ? ALPHA_FULL : 5);
					known_words.push_back(w);
				end
				send_word(OP_INSERT, w);
			end else if (roll < 80) begin
				w = known_words[$urandom_range(known_words.size() - 1)];
				if ($urandom_range(2) == 0)
					w.len = 6'($urandom_range(w.len, 1));
				op = (roll < 55) ? OP_ERASE :
					((roll < 68) ? OP_COUNT_WORD : OP_COUNT_PREFIX);
				send_word(op, w);
			end else if (roll < 90) begin
				send_word(op_t'($urandom_range(3, 1)), fresh_word(1, 5, ALPHA_FULL));
			end else begin
				noise_word();
			end
		end
	endtask

	// long fresh inserts that grow deep new branches of the node pool
	task automatic fill_pool(int n);
		word_t w;
		for (int i = 0; i < n; i++) begin
			w = fresh_word(24, 24, ALPHA_FULL);
			if (i % 20 == 0)
				known_words.push_back(w);
			send_word(OP_INSERT, w);
		end
	endtask

	initial begin : stimulus
		word_t w;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// insert "ab" and "z"
		send_letter(OP_INSERT, 5'd0, 1'b0);
		send_letter(OP_INSERT, 5'd1, 1'b1);
		send_letter(OP_INSERT, 5'd25, 1'b1);
		// count the word and its prefix
		send_letter(OP_COUNT_WORD, 5'd0, 1'b0);
		send_letter(OP_COUNT_WORD, 5'd1, 1'b1);
		send_letter(OP_COUNT_PREFIX, 5'd0, 1'b1);
		// erase a word never inserted: end count wraps below zero
		send_letter(OP_ERASE, 5'd0, 1'b1);
		send_letter(OP_COUNT_WORD, 5'd0, 1'b1);
		// count of a missing path
		send_letter(OP_COUNT_PREFIX, 5'd0, 1'b0);
		send_letter(OP_COUNT_PREFIX, 5'd2, 1'b1);
		// erase of a missing path keeps the decrement already made
		send_letter(OP_ERASE, 5'd25, 1'b0);
		send_letter(OP_ERASE, 5'd16, 1'b1);
		send_letter(OP_COUNT_PREFIX, 5'd25, 1'b1);
		// out-of-range letters, also on insert
		send_letter(OP_INSERT, 5'd31, 1'b1);
		send_letter(OP_INSERT, 5'd26, 1'b0);
		send_letter(OP_INSERT, 5'd3, 1'b1);
		// op changing inside a word
		send_letter(OP_INSERT, 5'd0, 1'b0);
		send_letter(OP_COUNT_PREFIX, 5'd1, 1'b1);
		// letters after a failure change nothing
		send_letter(OP_COUNT_WORD, 5'd7, 1'b0);
		send_letter(OP_INSERT, 5'd0, 1'b0);
		send_letter(OP_COUNT_WORD, 5'd1, 1'b1);
		send_letter(OP_ERASE, 5'd0, 1'b0);
		send_letter(OP_ERASE, 5'd1, 1'b1);
		drain();

		w        = '0;
		w.len    = 6'd2;
		w.sym[1] = 5'd1;
		known_words.push_back(w);

		// random words, a quiet stretch, a pause, then random words around long fresh inserts
		random_words(450);
		quiet = 1'b1;
		random_words(300);
		quiet = 1'b0;
		drain();
		random_words(300);
		fill_pool(10);
		random_words(150);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d letters in %0d words: all ops, misses, wrap below zero,",
			letters_sent, words_sent);
		$display("out-of-range letters, mixed ops per word and long fresh inserts");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/ptce_pkg.sv
hdl/ptce_ram.sv
hdl/ptce_alu.sv
hdl/prefix_tree_counter_engine_core.sv
tb/sv/trie_count_checker.sv
tb/sv/tb_prefix_tree_counter_engine_core.sv
